### rtl/i64au_pkg.sv
// ----------------------------------------------------------------------------
// i64au_pkg
// Shared types and codes of the 64-bit integer arithmetic unit.
// ----------------------------------------------------------------------------
package i64au_pkg;

   localparam int unsigned DataWidth  = 64;
   localparam int unsigned ActWidth   = 3;
   localparam int unsigned OrderWidth = 2;

   typedef enum logic [ActWidth-1:0] {
      ACT_ADD = 3'd0,
      ACT_SUB = 3'd1,
      ACT_NEG = 3'd2,
      ACT_CMP = 3'd3,
      ACT_SHR = 3'd4,
      ACT_MUL = 3'd5
   } action_type;

   localparam logic [OrderWidth-1:0] ORD_EQ = 2'd0;
   localparam logic [OrderWidth-1:0] ORD_LT = 2'd1;
   localparam logic [OrderWidth-1:0] ORD_GT = 2'd2;

   // operands presented to the shared adder
   typedef struct packed {
      logic [DataWidth-1:0] x;
      logic [DataWidth-1:0] y;
      logic                 cin;
   } add_req_type;

   typedef struct packed {
      logic [DataWidth-1:0] sum;
      logic                 cout;
   } add_rsp_type;

endpackage

### rtl/i64au_adder.sv
// ----------------------------------------------------------------------------
// i64au_adder
// Shared 64-bit adder with carry in and carry out, used by add, subtract, negate, compare and multiply.
// ----------------------------------------------------------------------------
module i64au_adder
   import i64au_pkg::*;
(
   input  add_req_type add_req,
   output add_rsp_type add_rsp
);

   logic [DataWidth:0] total;

   assign total = {1'b0, add_req.x} + {1'b0, add_req.y}
                + {{DataWidth{1'b0}}, add_req.cin};

   assign add_rsp.sum  = total[DataWidth-1:0];
   assign add_rsp.cout = total[DataWidth];

endmodule

### rtl/int64_arith_unit.sv
// ----------------------------------------------------------------------------
// int64_arith_unit
// Unsigned 64-bit arithmetic unit: add, subtract, negate, compare, shift
// right by one and shift-and-add multiply over one shared adder.
// ----------------------------------------------------------------------------
// Add, subtract, negate, compare and shift pass from idle through S_CALC,
// which registers the result; multiply steps through S_MUL, one multiplier
// bit per cycle, until the shifted operand_b is zero, then registers it.
// The unit takes no new item while busy, until the last result is registered.
// The receiver cannot stall; each result shows for one cycle.
// Synchronous active-high reset returns the unit to idle with no strobe.
// ----------------------------------------------------------------------------
module int64_arith_unit
   import i64au_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [ActWidth-1:0]   req_action,
   input  logic [DataWidth-1:0]  req_operand_a,
   input  logic [DataWidth-1:0]  req_operand_b,
   output logic                  rsp_strobe,
   output logic [DataWidth-1:0]  rsp_value,
   output logic                  rsp_flag,
   output logic [OrderWidth-1:0] rsp_order
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_MUL
   } state_type;

   state_type            state_ff;
   action_type           act_ff;
   logic [DataWidth-1:0] a_ff;
   logic [DataWidth-1:0] b_ff;
   logic [DataWidth-1:0] acc_ff;
   logic                 ovf_ff;
   logic                 rsp_strobe_ff;
   logic [DataWidth-1:0] rsp_value_ff;
   logic                 rsp_flag_ff;
   logic [OrderWidth-1:0] rsp_order_ff;

   logic [DataWidth-1:0] calc_value_in;
   logic                 calc_flag_in;
   logic [OrderWidth-1:0] calc_order_in;

   add_req_type add_req;
   add_rsp_type add_rsp;

   logic accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   i64au_adder u_adder (
      .add_req (add_req),
      .add_rsp (add_rsp)
   );

   // adder operand selection
   always_comb begin
      add_req = '{x: a_ff, y: b_ff, cin: 1'b0};
      if (state_ff == S_MUL) begin
         add_req = '{x: acc_ff, y: a_ff, cin: 1'b0};
      end else begin
         unique case (act_ff)
            ACT_SUB, ACT_CMP: add_req = '{x: a_ff, y: ~b_ff, cin: 1'b1};
            ACT_NEG:          add_req = '{x: ~a_ff, y: '0, cin: 1'b1};
            default:          add_req = '{x: a_ff, y: b_ff, cin: 1'b0};
         endcase
      end
   end

   // single-pass actions
   always_comb begin
      calc_value_in = '0;
      calc_flag_in  = 1'b0;
      calc_order_in = ORD_EQ;
      unique case (act_ff)
         ACT_ADD: begin
            calc_value_in = add_rsp.sum;
            calc_flag_in  = add_rsp.cout;
         end
         ACT_SUB: begin
            calc_value_in = add_rsp.sum;
            calc_flag_in  = !add_rsp.cout;
         end
         ACT_NEG: begin
            calc_value_in = add_rsp.sum;
         end
         ACT_CMP: begin
            // no carry out of a - b means a borrow, so a < b
            priority if (!add_rsp.cout) begin
               calc_order_in = ORD_LT;
            end else if (add_rsp.sum == '0) begin
               calc_order_in = ORD_EQ;
            end else begin
               calc_order_in = ORD_GT;
            end
         end
         ACT_SHR: begin
            calc_value_in = a_ff >> 1;
         end
         default: begin
            calc_value_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rsp_strobe_ff <= 1'b0;
               if (accept) begin
                  act_ff <= action_type'(req_action);
                  a_ff   <= req_operand_a;
                  b_ff   <= req_operand_b;
                  acc_ff <= '0;
                  ovf_ff <= 1'b0;
                  state_ff <= (action_type'(req_action) == ACT_MUL) ? S_MUL : S_CALC;
               end
            end
            S_CALC: begin
               rsp_value_ff  <= calc_value_in;
               rsp_flag_ff   <= calc_flag_in;
               rsp_order_ff  <= calc_order_in;
               rsp_strobe_ff <= 1'b1;
               state_ff      <= S_IDLE;
            end
            S_MUL: begin
               if (b_ff == '0) begin
                  rsp_value_ff  <= acc_ff;
                  rsp_flag_ff   <= ovf_ff;
                  rsp_order_ff  <= ORD_EQ;
                  rsp_strobe_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  rsp_strobe_ff <= 1'b0;
                  if (b_ff[0]) begin
                     acc_ff <= add_rsp.sum;
                     ovf_ff <= ovf_ff | add_rsp.cout;
                  end
                  // multiplicand bits past bit 63 drop out silently
                  a_ff <= {a_ff[DataWidth-2:0], 1'b0};
                  b_ff <= b_ff >> 1;
               end
            end
            default: begin
               rsp_strobe_ff <= 1'b0;
               state_ff      <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_flag   = rsp_flag_ff;
   assign rsp_order  = rsp_order_ff;

`ifndef SYNTH
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("unit not busy after start transfer");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without work in progress");

   a_order_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_order != ORD_EQ) |-> (rsp_value == '0 && !rsp_flag))
      else $error("compare result carries value or flag");

   a_mul_shift: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL && b_ff != '0) |=> (b_ff == ($past(b_ff) >> 1)))
      else $error("multiplier did not advance one bit");
`endif

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for int64_arith_unit: directed corner items for every
// action, then a long random mix with bursty idling and a back-to-back tail.
// Each result is checked field by field against an in-bench model.
// ----------------------------------------------------------------------------
module tb;
   import i64au_pkg::*;

   localparam logic [ActWidth-1:0]  ACT_SPARE6   = 3'd6;
   localparam logic [ActWidth-1:0]  ACT_SPARE7   = 3'd7;
   localparam logic [DataWidth-1:0] ALL_ONES     = '1;
   localparam logic [DataWidth-1:0] TOP_BIT      = 64'h8000_0000_0000_0000;
   localparam logic [DataWidth-1:0] HALF_WORD    = 64'h0000_0000_8000_0000;
   localparam int unsigned          DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [DataWidth-1:0]  value;
      logic                  flag;
      logic [OrderWidth-1:0] order;
   } alu_result_type;

   logic                  clock         = 1'b0;
   logic                  reset         = 1'b1;
   logic                  start         = 1'b0;
   logic                  busy;
   logic [ActWidth-1:0]   req_action    = '0;
   logic [DataWidth-1:0]  req_operand_a = '0;
   logic [DataWidth-1:0]  req_operand_b = '0;
   logic                  rsp_strobe;
   logic [DataWidth-1:0]  rsp_value;
   logic                  rsp_flag;
   logic [OrderWidth-1:0] rsp_order;

   alu_result_type pending_results[$];
   int unsigned sent_count[8];
   int unsigned results_checked = 0;
   int unsigned mismatches      = 0;
   int unsigned mul_carries     = 0;
   bit          idling_on       = 1'b1;

   int64_arith_unit dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_action    (req_action),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_strobe    (rsp_strobe),
      .rsp_value     (rsp_value),
      .rsp_flag      (rsp_flag),
      .rsp_order     (rsp_order)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb: done, errors");
      $finish;
   end

   function automatic alu_result_type arith_result(logic [ActWidth-1:0] act,
                                                   logic [DataWidth-1:0] a,
                                                   logic [DataWidth-1:0] b);
      alu_result_type       r;
      logic [DataWidth:0]   wide;
      logic [DataWidth-1:0] mcand;
      logic [DataWidth-1:0] mplier;
      r = '0;
      case (act)
         ACT_ADD: begin
            wide    = {1'b0, a} + {1'b0, b};
            r.value = wide[DataWidth-1:0];
            r.flag  = wide[DataWidth];
         end
         ACT_SUB: begin
            r.value = a - b;
            r.flag  = (a < b);
         end
         ACT_NEG: r.value = ~a + 64'd1;
         ACT_CMP: r.order = (a < b) ? ORD_LT : ((a > b) ? ORD_GT : ORD_EQ);
         ACT_SHR: r.value = a >> 1;
         ACT_MUL: begin
            // carry only from the accumulate, bits shifted out of mcand are lost
            mcand  = a;
            mplier = b;
            while (mplier != '0) begin
               if (mplier[0]) begin
                  wide = {1'b0, r.value} + {1'b0, mcand};
                  if (wide[DataWidth]) r.flag = 1'b1;
                  r.value = wide[DataWidth-1:0];
               end
               mcand  = mcand << 1;
               mplier = mplier >> 1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [DataWidth-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ONES;
         2: return TOP_BIT;
         3: return 64'd1 << $urandom_range(0, 63);
         4: return 64'($urandom_range(0, 255));
         5: return ALL_ONES - 64'($urandom_range(0, 255));
         6: return {$urandom, $urandom} >> $urandom_range(1, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic idle_cycles(int unsigned n);
      repeat (n) begin
         @(negedge clock);
         start         = 1'b0;
         req_action    = 3'($urandom);
         req_operand_a = {$urandom, $urandom};
         req_operand_b = {$urandom, $urandom};
      end
   endtask

   // start stays high on return so the next item can follow without a gap
   task automatic send_op(logic [ActWidth-1:0] act, logic [DataWidth-1:0] a,
                          logic [DataWidth-1:0] b);
      alu_result_type want;
      if (idling_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 19));
      @(negedge clock);
      start         = 1'b1;
      req_action    = act;
      req_operand_a = a;
      req_operand_b = b;
      do @(posedge clock); while (busy);
      want = arith_result(act, a, b);
      pending_results.push_back(want);
      sent_count[act]++;
      if (act == ACT_MUL && want.flag) mul_carries++;
   endtask

   task automatic wait_results_done();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_add();
      send_op(ACT_ADD, '0, '0);
      send_op(ACT_ADD, ALL_ONES, 64'd1);
      send_op(ACT_ADD, ALL_ONES, ALL_ONES);
   endtask

   task automatic test_subtract();
      send_op(ACT_SUB, '0, 64'd1);
      send_op(ACT_SUB, 64'd5, 64'd5);
      send_op(ACT_SUB, ALL_ONES, '0);
   endtask

   task automatic test_negate();
      send_op(ACT_NEG, '0, ALL_ONES);
      send_op(ACT_NEG, TOP_BIT, '0);
      send_op(ACT_NEG, ALL_ONES, 64'h1234_5678_9abc_def0);
   endtask

   task automatic test_compare();
      send_op(ACT_CMP, '0, ALL_ONES);
      send_op(ACT_CMP, ALL_ONES, ALL_ONES);
      send_op(ACT_CMP, ALL_ONES, ALL_ONES - 64'd1);
   endtask

   task automatic test_shift();
      send_op(ACT_SHR, ALL_ONES, '0);
      send_op(ACT_SHR, 64'd1, ALL_ONES);
   endtask

   task automatic test_multiply();
      send_op(ACT_MUL, ALL_ONES, '0);
      send_op(ACT_MUL, HALF_WORD, HALF_WORD);
      // top bit doubled away: product lost with no carry
      send_op(ACT_MUL, TOP_BIT, 64'd2);
      send_op(ACT_MUL, ALL_ONES, ALL_ONES);
      send_op(ACT_MUL, 64'd3, TOP_BIT);
   endtask

   task automatic test_unused_actions();
      send_op(ACT_SPARE6, ALL_ONES, ALL_ONES);
      send_op(ACT_SPARE7, TOP_BIT, 64'd1);
   endtask

   task automatic send_random_op();
      logic [ActWidth-1:0]  act;
      logic [DataWidth-1:0] a;
      logic [DataWidth-1:0] b;
      if ($urandom_range(0, 19) == 0)
         act = ($urandom_range(0, 1) != 0) ? ACT_SPARE6 : ACT_SPARE7;
      else
         act = 3'($urandom_range(ACT_ADD, ACT_MUL));
      a = pick_operand();
      b = pick_operand();
      // near-equal operands for compare and subtract borrow edges
      if ((act == ACT_CMP || act == ACT_SUB) && $urandom_range(0, 2) == 0)
         b = a + 64'($urandom_range(0, 2)) - 64'd1;
      send_op(act, a, b);
   endtask

   task automatic test_random_mix(int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
         if (i == n / 2) wait_results_done();
         send_random_op();
      end
   endtask

   task automatic test_back_to_back(int unsigned n);
      repeat (n) send_random_op();
   endtask

   always @(posedge clock) begin : check_results
      alu_result_type want;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("tb: unexpected result: value %h flag %b order %0d",
                        rsp_value, rsp_flag, rsp_order);
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_value !== want.value || rsp_flag !== want.flag ||
                rsp_order !== want.order) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"tb: mismatch: expected value %h flag %b order %0d, ",
                            "got value %h flag %b order %0d"},
                           want.value, want.flag, want.order,
                           rsp_value, rsp_flag, rsp_order);
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_add();
      test_subtract();
      test_negate();
      test_compare();
      test_shift();
      test_multiply();
      test_unused_actions();
      test_random_mix(900);
      idling_on = 1'b0;
      test_back_to_back(250);

      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: sent add %0d sub %0d neg %0d cmp %0d shr %0d mul %0d unused %0d",
               sent_count[ACT_ADD], sent_count[ACT_SUB], sent_count[ACT_NEG],
               sent_count[ACT_CMP], sent_count[ACT_SHR], sent_count[ACT_MUL],
               sent_count[ACT_SPARE6] + sent_count[ACT_SPARE7]);
      $display("tb: %0d results checked, %0d multiply carries, %0d mismatches",
               results_checked, mul_carries, mismatches);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

### int64_arith_unit.f
rtl/i64au_pkg.sv
rtl/i64au_adder.sv
rtl/int64_arith_unit.sv
sim/tb.sv
